// ===== design/optimal_line_break_dp_top_assert.svh =====
`ifndef OPTIMAL_LINE_BREAK_DP_TOP_ASSERT_SVH
`define OPTIMAL_LINE_BREAK_DP_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OLB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/olb_pkg.sv =====
package olb_pkg;

    localparam int MAX_WORDS_DEF = 64;

    localparam int WIDTH_W  = 12;
    localparam int GAP_W    = 9;
    localparam int HYP_W    = 8;
    localparam int CFG_W    = 12;
    localparam int OUT_W    = 7;
    localparam int WORD_W   = WIDTH_W + GAP_W + 2 + HYP_W;
    localparam int DEM_W    = 32;
    localparam int LEN_W    = 21;
    localparam int AV_W     = 14;
    localparam int D_W      = 15;
    localparam int W_W      = 13;
    localparam int NUM_W    = 62;
    localparam int Q_W      = 22;
    localparam int DIV_CNT_W = 5;

    localparam logic [DEM_W-1:0] INF_BAD   = 32'd2560000;
    localparam logic [DEM_W-1:0] LINE_PEN  = 32'd12800;
    localparam logic [DEM_W-1:0] HYPH_PEN  = 32'd12800;
    localparam logic [DEM_W-1:0] START_DEM = 32'd2560000000;
    localparam logic [DEM_W-1:0] Q8_ONE    = 32'd256;
    localparam logic [6:0]       BAD_SCALE = 7'd100;

    localparam logic [WIDTH_W-1:0] PAGE_WIDTH_RST = 12'd480;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_PAGE_WIDTH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_INDENT     = 1'b1;

    typedef enum logic [4:0] {
        ST_LOAD, ST_INIT, ST_ROW, ST_WJ, ST_WN, ST_EVAL, ST_MUL1, ST_MUL2,
        ST_MUL3, ST_DIVI, ST_DIV, ST_SQ, ST_SUM, ST_UPD, ST_NEXTJ, ST_ROWEND,
        ST_ERD, ST_ECAP, ST_EOUT
    } state_t;

    typedef enum logic [4:0] {
        OP_IDLE, OP_LOAD, OP_INIT, OP_ROW, OP_CAPJ, OP_STEP, OP_EVAL,
        OP_MUL1, OP_MUL2, OP_MUL3, OP_DIVI, OP_DIV, OP_SQ, OP_SUM, OP_UPD,
        OP_TAKE_LAST, OP_NEXTJ, OP_ROWEND, OP_ERD, OP_ECAP, OP_EDONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic single;
        logic over;
        logic skip;
        logic last;
        logic div_done;
        logic row_zero;
        logic emit_last;
    } sts_t;

endpackage

// ===== design/olb_ram.sv =====
module olb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/olb_ctrl.sv =====
module olb_ctrl import olb_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tlast,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd,
    output logic s_tready,
    output logic m_tvalid
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_IDLE;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_LOAD;
                    if (s_tlast)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.op     = OP_INIT;
                state_next = sts.single ? ST_ERD : ST_ROW;
            end
            ST_ROW:
            begin
                cmd.op     = OP_ROW;
                state_next = ST_WJ;
            end
            ST_WJ:
            begin
                cmd.op     = OP_CAPJ;
                state_next = ST_WN;
            end
            ST_WN:
            begin
                cmd.op     = OP_STEP;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (sts.over)
                begin
                    state_next = ST_ROWEND;
                end
                else if (sts.skip)
                begin
                    state_next = ST_NEXTJ;
                end
                else if (sts.last)
                begin
                    cmd.op     = OP_TAKE_LAST;
                    state_next = ST_ROWEND;
                end
                else
                begin
                    cmd.op     = OP_EVAL;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.op     = OP_MUL3;
                state_next = ST_DIVI;
            end
            ST_DIVI:
            begin
                cmd.op     = OP_DIVI;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (sts.div_done)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.op     = OP_UPD;
                state_next = ST_NEXTJ;
            end
            ST_NEXTJ:
            begin
                cmd.op     = OP_NEXTJ;
                state_next = ST_WJ;
            end
            ST_ROWEND:
            begin
                cmd.op     = OP_ROWEND;
                state_next = sts.row_zero ? ST_ERD : ST_ROW;
            end
            ST_ERD:
            begin
                cmd.op     = OP_ERD;
                state_next = ST_ECAP;
            end
            ST_ECAP:
            begin
                cmd.op     = OP_ECAP;
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    cmd.op     = OP_EDONE;
                    state_next = sts.emit_last ? ST_LOAD : ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// ===== design/olb_dp.sv =====
module olb_dp import olb_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output sts_t                       sts,
    input  logic [WIDTH_W-1:0]         word_width,
    input  logic signed [GAP_W-1:0]    gap_before,
    input  logic                       attaches,
    input  logic                       split_prefix,
    input  logic [HYP_W-1:0]           hyphen_extra,
    input  logic                       last_word,
    input  logic                       cfg_we,
    input  logic [REG_IDX_W-1:0]       cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    output logic [OUT_W-1:0]           next_line_start,
    output logic                       line_last
);

    localparam int AW    = $clog2(MAX_WORDS);
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int BEST_W = DEM_W + AW;

    // configuration and control
    logic [WIDTH_W-1:0] page_width_reg;
    logic [CFG_W-1:0]   indent_reg;
    logic [CW-1:0]      count_reg, count_next;

    // payload
    logic [CW-1:0]             n_reg, n_next;
    logic [AW-1:0]             i_reg, i_next;
    logic [AW-1:0]             j_reg, j_next;
    logic [CW-1:0]             cur_reg, cur_next;
    logic signed [LEN_W-1:0]   len_reg, len_next;
    logic signed [AV_W-1:0]    avail_reg, avail_next;
    logic [WIDTH_W-1:0]        wj_width_reg, wj_width_next;
    logic signed [GAP_W-1:0]   wj_gap_reg, wj_gap_next;
    logic                      wj_split_reg, wj_split_next;
    logic [HYP_W-1:0]          wj_hyp_reg, wj_hyp_next;
    logic                      nxt_att_reg, nxt_att_next;
    logic [DEM_W-1:0]          bnext_reg, bnext_next;
    logic [DEM_W-1:0]          bi1_reg, bi1_next;
    logic [DEM_W-1:0]          best_reg, best_next;
    logic [AW-1:0]             end_reg, end_next;
    logic                      found_reg, found_next;
    logic                      inf_reg, inf_next;
    logic [D_W-1:0]            d_reg, d_next;
    logic [W_W-1:0]            w_reg, w_next;
    logic [2*D_W-1:0]          d2_reg, d2_next;
    logic [2*W_W-1:0]          w2_reg, w2_next;
    logic [2*D_W+6:0]          d2h_reg, d2h_next;
    logic [3*W_W-1:0]          w3_reg, w3_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [3*W_W-1:0]          den_reg, den_next;
    logic [NUM_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          dsh_reg, dsh_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                      binf_reg, binf_next;
    logic [2*Q_W+1:0]          sq_reg, sq_next;
    logic [DEM_W-1:0]          cost_reg, cost_next;
    logic [OUT_W-1:0]          out_next_reg, out_next_next;
    logic                      out_last_reg, out_last_next;

    // memories
    logic                 word_we;
    logic [AW-1:0]        word_waddr, word_raddr;
    logic [WORD_W-1:0]    word_wdata, word_rdata;
    logic                 best_we;
    logic [AW-1:0]        best_waddr, best_raddr;
    logic [BEST_W-1:0]    best_wdata, best_rdata;

    // helpers
    logic                    has_room;
    logic [CW-1:0]           n_load;
    logic [CW-1:0]           j1;
    logic                    j1_lt_n;
    logic                    last_j;
    logic                    hyph;
    logic signed [LEN_W-1:0] avail_ext;
    logic signed [LEN_W-1:0] eff;
    logic [NUM_W-1:0]        den_sh_top;
    logic                    div_ge;
    logic [Q_W:0]            q_plus;
    logic [2*Q_W-5:0]        c_sum;
    logic [DEM_W:0]          tot_wide;
    logic [DEM_W-1:0]        total;
    logic [OUT_W-1:0]        nx;

    olb_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (word_wdata),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    olb_ram #(.WIDTH(BEST_W), .DEPTH(MAX_WORDS)) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    assign has_room   = count_reg < CW'(MAX_WORDS);
    assign n_load     = has_room ? count_reg + CW'(1) : count_reg;
    assign j1         = CW'(j_reg) + CW'(1);
    assign j1_lt_n    = j1 < n_reg;
    assign last_j     = CW'(j_reg) == n_reg - CW'(1);
    assign hyph       = !last_j && wj_split_reg;
    assign avail_ext  = LEN_W'(avail_reg);
    assign eff        = len_reg + (hyph ? LEN_W'(signed'({1'b0, wj_hyp_reg})) : LEN_W'(0));
    assign den_sh_top = NUM_W'({den_reg, {Q_W{1'b0}}});
    assign div_ge     = rem_reg >= dsh_reg;
    assign q_plus     = (Q_W+1)'(q_reg) + (Q_W+1)'(Q8_ONE);
    assign c_sum      = (2*Q_W-4)'(sq_reg[2*Q_W+1:8]) + (2*Q_W-4)'(LINE_PEN)
                      + (hyph ? (2*Q_W-4)'(HYPH_PEN) : (2*Q_W-4)'(0));
    assign tot_wide   = {1'b0, cost_reg} + {1'b0, bnext_reg};
    assign total      = tot_wide[DEM_W] ? {DEM_W{1'b1}} : tot_wide[DEM_W-1:0];
    assign nx         = (OUT_W'(best_rdata[DEM_W +: AW]) + OUT_W'(1) <= OUT_W'(cur_reg))
                      ? OUT_W'(cur_reg) + OUT_W'(1)
                      : OUT_W'(best_rdata[DEM_W +: AW]) + OUT_W'(1);

    assign sts.single    = n_reg == CW'(1);
    assign sts.over      = len_reg > avail_ext;
    assign sts.skip      = nxt_att_reg && !wj_split_reg;
    assign sts.last      = last_j;
    assign sts.div_done  = cnt_reg == '0;
    assign sts.row_zero  = i_reg == '0;
    assign sts.emit_last = out_last_reg;

    assign next_line_start = out_next_reg;
    assign line_last       = out_last_reg;

    assign word_we    = (cmd.op == OP_LOAD) && has_room;
    assign word_waddr = count_reg[AW-1:0];
    assign word_wdata = {hyphen_extra, split_prefix, attaches, gap_before, word_width};

    always_comb
    begin
        case (cmd.op)
            OP_ROW:   word_raddr = i_reg;
            OP_CAPJ:  word_raddr = j1_lt_n ? j1[AW-1:0] : j_reg;
            OP_NEXTJ: word_raddr = j1[AW-1:0];
            default:  word_raddr = j_reg;
        endcase
    end

    assign best_raddr = (cmd.op == OP_ERD) ? cur_reg[AW-1:0]
                      : (j1_lt_n ? j1[AW-1:0] : j_reg);

    always_comb
    begin
        best_we    = 1'b0;
        best_waddr = i_reg;
        best_wdata = found_reg ? {end_reg, best_reg} : {i_reg, bi1_reg};
        case (cmd.op)
            OP_INIT:
            begin
                best_we    = 1'b1;
                best_waddr = AW'(n_reg - CW'(1));
                best_wdata = {AW'(n_reg - CW'(1)), {DEM_W{1'b0}}};
            end
            OP_ROWEND:
            begin
                best_we = 1'b1;
            end
            default:
            begin
                best_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        n_next        = n_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        cur_next      = cur_reg;
        len_next      = len_reg;
        avail_next    = avail_reg;
        wj_width_next = wj_width_reg;
        wj_gap_next   = wj_gap_reg;
        wj_split_next = wj_split_reg;
        wj_hyp_next   = wj_hyp_reg;
        nxt_att_next  = nxt_att_reg;
        bnext_next    = bnext_reg;
        bi1_next      = bi1_reg;
        best_next     = best_reg;
        end_next      = end_reg;
        found_next    = found_reg;
        inf_next      = inf_reg;
        d_next        = d_reg;
        w_next        = w_reg;
        d2_next       = d2_reg;
        w2_next       = w2_reg;
        d2h_next      = d2h_reg;
        w3_next       = w3_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        binf_next     = binf_reg;
        sq_next       = sq_reg;
        cost_next     = cost_reg;
        out_next_next = out_next_reg;
        out_last_next = out_last_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                count_next = last_word ? '0 : n_load;
                if (last_word)
                begin
                    n_next = n_load;
                end
            end
            OP_INIT:
            begin
                i_next   = AW'(n_reg - CW'(2));
                cur_next = '0;
            end
            OP_ROW:
            begin
                j_next     = i_reg;
                len_next   = '0;
                best_next  = START_DEM;
                found_next = 1'b0;
                avail_next = AV_W'(signed'({1'b0, page_width_reg}))
                           - ((i_reg == '0) ? AV_W'(signed'(indent_reg)) : AV_W'(0));
            end
            OP_CAPJ:
            begin
                wj_width_next = word_rdata[WIDTH_W-1:0];
                wj_gap_next   = signed'(word_rdata[WIDTH_W +: GAP_W]);
                wj_split_next = word_rdata[WIDTH_W+GAP_W+1];
                wj_hyp_next   = word_rdata[WORD_W-1 -: HYP_W];
            end
            OP_STEP:
            begin
                len_next = len_reg + LEN_W'(signed'({1'b0, wj_width_reg}))
                         + ((j_reg != i_reg) ? LEN_W'(wj_gap_reg) : LEN_W'(0));
                nxt_att_next = j1_lt_n && word_rdata[WIDTH_W+GAP_W];
                bnext_next   = best_rdata[DEM_W-1:0];
                if (j_reg == i_reg)
                begin
                    bi1_next = best_rdata[DEM_W-1:0];
                end
            end
            OP_EVAL:
            begin
                inf_next = (avail_reg <= AV_W'(0)) || (eff > avail_ext);
                d_next   = D_W'(avail_ext - eff);
                w_next   = W_W'(avail_reg);
            end
            OP_MUL1:
            begin
                d2_next = (2*D_W)'(d_reg) * (2*D_W)'(d_reg);
                w2_next = (2*W_W)'(w_reg) * (2*W_W)'(w_reg);
            end
            OP_MUL2:
            begin
                d2h_next = (2*D_W+7)'(d2_reg) * (2*D_W+7)'(BAD_SCALE);
                w3_next  = (3*W_W)'(w2_reg) * (3*W_W)'(w_reg);
            end
            OP_MUL3:
            begin
                num_next = NUM_W'({(3*D_W+7)'(d2h_reg) * (3*D_W+7)'(d_reg), 8'h00});
                den_next = w3_reg;
            end
            OP_DIVI:
            begin
                binf_next = inf_reg || (num_reg >= den_sh_top);
                rem_next  = num_reg;
                dsh_next  = NUM_W'({den_reg, {(Q_W-1){1'b0}}});
                q_next    = '0;
                cnt_next  = DIV_CNT_W'(Q_W - 1);
            end
            OP_DIV:
            begin
                rem_next = div_ge ? rem_reg - dsh_reg : rem_reg;
                q_next   = {q_reg[Q_W-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - DIV_CNT_W'(1);
            end
            OP_SQ:
            begin
                sq_next = (2*Q_W+2)'(q_plus) * (2*Q_W+2)'(q_plus);
            end
            OP_SUM:
            begin
                if (binf_reg || (q_reg >= Q_W'(INF_BAD)))
                begin
                    cost_next = INF_BAD;
                end
                else if (c_sum > (2*Q_W-4)'({DEM_W{1'b1}}))
                begin
                    cost_next = {DEM_W{1'b1}};
                end
                else
                begin
                    cost_next = c_sum[DEM_W-1:0];
                end
            end
            OP_UPD:
            begin
                if (total < best_reg)
                begin
                    best_next  = total;
                    end_next   = j_reg;
                    found_next = 1'b1;
                end
            end
            OP_TAKE_LAST:
            begin
                best_next  = '0;
                end_next   = j_reg;
                found_next = 1'b1;
            end
            OP_NEXTJ:
            begin
                j_next = j1[AW-1:0];
            end
            OP_ROWEND:
            begin
                i_next = i_reg - AW'(1);
            end
            OP_ECAP:
            begin
                out_next_next = nx;
                out_last_next = nx >= OUT_W'(n_reg);
            end
            OP_EDONE:
            begin
                cur_next = CW'(out_next_reg);
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            page_width_reg <= PAGE_WIDTH_RST;
            indent_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we && (cfg_addr == REG_PAGE_WIDTH))
            begin
                page_width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_addr == REG_INDENT))
            begin
                indent_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        cur_reg      <= cur_next;
        len_reg      <= len_next;
        avail_reg    <= avail_next;
        wj_width_reg <= wj_width_next;
        wj_gap_reg   <= wj_gap_next;
        wj_split_reg <= wj_split_next;
        wj_hyp_reg   <= wj_hyp_next;
        nxt_att_reg  <= nxt_att_next;
        bnext_reg    <= bnext_next;
        bi1_reg      <= bi1_next;
        best_reg     <= best_next;
        end_reg      <= end_next;
        found_reg    <= found_next;
        inf_reg      <= inf_next;
        d_reg        <= d_next;
        w_reg        <= w_next;
        d2_reg       <= d2_next;
        w2_reg       <= w2_next;
        d2h_reg      <= d2h_next;
        w3_reg       <= w3_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        binf_reg     <= binf_next;
        sq_reg       <= sq_next;
        cost_reg     <= cost_next;
        out_next_reg <= out_next_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== design/optimal_line_break_dp_top.sv =====
// Optimal paragraph line breaker (minimum total demerits).
// Input stream: one transaction per word; s_tlast marks the paragraph's last
// word and starts the solve. Words past MAX_WORDS are dropped.
// Output stream: one transaction per line, m_tdata giving the index of the
// first word of the following line, m_tlast set on the final line.
// Loading accepts one word per cycle. The solve walks every start word from
// right to left and every candidate line end; a costed end passes through
// three multiply stages and a one-bit-per-cycle divider for badness, a
// skipped end through none of these, so the solve time grows roughly with the
// number of words times the number that fit on one line. Each line result
// is then read from the table, captured and offered on the output.
// While solving or emitting, s_tready is low. A stalled m_tready holds the
// current line result in the output register until it is taken.
// Reset empties the word buffer, sets page_width 480, indent 0. User rule:
// registers are written through cfg_we/cfg_addr/cfg_wdata while idle, unchecked.
module optimal_line_break_dp_top import olb_pkg::*; #(
    parameter int MAX_WORDS = MAX_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // word_width, gap_before, hyphen_extra
    input  logic [1:0]           s_tuser,   // attaches, split_prefix
    input  logic                 s_tlast,   // last_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // next_line_start
    output logic                 m_tlast,   // line_last
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cmd_t             cmd;
    sts_t             sts;
    logic [OUT_W-1:0] next_line_start;

    olb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    olb_dp #(.MAX_WORDS(MAX_WORDS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .word_width      (s_tdata[11:0]),
        .gap_before      (s_tdata[20:12]),
        .attaches        (s_tuser[0]),
        .split_prefix    (s_tuser[1]),
        .hyphen_extra    (s_tdata[28:21]),
        .last_word       (s_tlast),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .next_line_start (next_line_start),
        .line_last       (m_tlast)
    );

    assign m_tdata = {1'b0, next_line_start};

endmodule

// ===== design/olb_checker.sv =====
`include "optimal_line_break_dp_top_assert.svh"

module olb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `OLB_ASSERT_NOW(a_no_load_while_emit, s_tready, !m_tvalid, "input ready while emitting")
    `OLB_ASSERT_NEXT(a_solve_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input still ready after last word")
    `OLB_ASSERT_NEXT(a_idle_after_final, m_tvalid && m_tready && m_tlast, !m_tvalid, "result after final line")
    `OLB_ASSERT_NOW(a_start_nonzero, m_tvalid, m_tdata != 8'd0, "next line start of zero")
    `OLB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind optimal_line_break_dp_top olb_checker u_olb_checker (.*);
